>>> src/sqt3_pkg.sv
// ----------------------------------------------------------------------------
// sqt3_pkg: shared types and constants for the smallest-three decoder
// Field widths, dequantization constants and the beat that runs down the
// square-root cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package sqt3_pkg;

   localparam int CODE_W      = 15;   // quantized component code
   localparam int Q14_W       = 16;   // signed Q2.14 result
   localparam int MAG_W       = 15;   // |2q - 32767|
   localparam int V30_W       = 30;   // component magnitude in Q1.30
   localparam int SQ_W        = 60;   // square of a Q1.30 magnitude
   localparam int SUM_W       = 61;   // sum of three squares
   localparam int RAD_W       = 62;   // radicand, padded to whole digit pairs
   localparam int ROOT_W      = 31;   // floor(sqrt) of the radicand
   localparam int PART_W      = 33;   // partial remainder of the root
   localparam int NUM_CELLS   = RAD_W / 2;
   localparam int FRONT_STAGES = 3;   // dequantizer depth
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 4 * Q14_W;

   // 3037000500 / 131068 = 23171 remainder 23872
   localparam logic [MAG_W-1:0]  COEF_INT   = 15'd23171;
   localparam logic [MAG_W-1:0]  COEF_FRAC  = 15'd23872;
   localparam logic [V30_W-1:0]  ROUND_HALF = 30'd65534;
   localparam logic [17:0]       DIVISOR    = 18'd131068;
   localparam logic [15:0]       CODE_MAX   = 16'd32767;
   localparam logic [SUM_W-1:0]  ONE_Q60    = 61'h1000_0000_0000_0000;
   localparam logic [V30_W-1:0]  HALF_Q14   = 30'd32768;
   localparam logic [ROOT_W-1:0] HALF_ROOT  = 31'd32768;

   typedef enum logic [1:0] {
      DROP_X = 2'd0,
      DROP_Y = 2'd1,
      DROP_Z = 2'd2,
      DROP_W = 2'd3
   } drop_type;

   typedef struct packed {
      drop_type                 drop;
      logic signed [Q14_W-1:0]  comp_a;
      logic signed [Q14_W-1:0]  comp_b;
      logic signed [Q14_W-1:0]  comp_c;
   } side_type;

   typedef struct packed {
      logic                valid;
      side_type            side;
      logic [RAD_W-1:0]    rad;
      logic [ROOT_W-1:0]   root;
      logic [PART_W-1:0]   part;
   } cell_beat_type;

endpackage

`default_nettype wire

>>> src/sqt3_comp.sv
// ----------------------------------------------------------------------------
// sqt3_comp: component dequantizer
// In three stages (A to C), maps one 15-bit code to its Q1.30 magnitude and
// then gives the rounded Q2.14 value and the exact square of the Q1.30 magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module sqt3_comp
   import sqt3_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    enable,
   input  wire logic [CODE_W-1:0]       code,
   output logic      [SQ_W-1:0]         square,
   output logic signed [Q14_W-1:0]     value
);

   logic [15:0]        two_q;
   logic [MAG_W-1:0]   mag;
   logic [V30_W-1:0]   base_in, base_ff;
   logic [V30_W-1:0]   frac_in, frac_ff;
   logic               neg_in, neg_ff, neg2_ff;
   logic [12:0]        coarse;
   logic [17:0]        resid;
   logic [13:0]        quot;
   logic [V30_W-1:0]   mag30_in, mag30_ff;
   logic [SQ_W-1:0]    square_in, square_ff;
   logic [V30_W-1:0]   rounded;
   logic signed [Q14_W-1:0] value_in, value_ff;

   // stage A: magnitude of 2q - 32767 times the split reciprocal constant
   assign two_q   = {code, 1'b0};
   assign mag     = code[CODE_W-1] ? MAG_W'(two_q - CODE_MAX) : MAG_W'(CODE_MAX - two_q);
   assign neg_in  = ~code[CODE_W-1];
   assign base_in = V30_W'(mag) * V30_W'(COEF_INT);
   assign frac_in = V30_W'(mag) * V30_W'(COEF_FRAC) + ROUND_HALF;

   // stage B: divide by 131068; the shift by 17 undershoots by at most one
   assign coarse   = frac_ff[29:17];
   assign resid    = 18'(frac_ff[16:0]) + {3'b000, coarse, 2'b00};
   assign quot     = 14'(coarse) + 14'(resid >= DIVISOR);
   assign mag30_in = base_ff + V30_W'(quot);

   // stage C: square of the Q1.30 magnitude, round to Q2.14
   assign square_in = {30'd0, mag30_ff} * {30'd0, mag30_ff};
   assign rounded   = mag30_ff + HALF_Q14;
   assign value_in  = neg2_ff ? -$signed(Q14_W'(rounded[29:16]))
                              :  $signed(Q14_W'(rounded[29:16]));

   always_ff @(posedge clock) begin
      if (enable) begin
         base_ff   <= base_in;
         frac_ff   <= frac_in;
         neg_ff    <= neg_in;
         mag30_ff  <= mag30_in;
         neg2_ff   <= neg_ff;
         square_ff <= square_in;
         value_ff  <= value_in;
      end
   end

   assign square = square_ff;
   assign value  = value_ff;

endmodule

`default_nettype wire

>>> src/sqt3_cell.sv
// ----------------------------------------------------------------------------
// sqt3_cell: one digit-pair step of the square-root chain
// Takes the next two radicand bits, tries the new root bit, registers the
// updated root and remainder and hands the beat to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sqt3_cell
   import sqt3_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          enable,
   input  wire cell_beat_type beat_in,
   output cell_beat_type      beat_out
);

   logic [PART_W+1:0] pending;
   logic [PART_W+1:0] trial;
   logic              fits;
   cell_beat_type     beat_in_n;
   logic              valid_ff;
   cell_beat_type     data_ff;

   assign pending = {beat_in.part, beat_in.rad[RAD_W-1 -: 2]};
   assign trial   = (PART_W+2)'({beat_in.root, 2'b01});
   assign fits    = pending >= trial;

   always_comb begin
      beat_in_n       = beat_in;
      beat_in_n.rad   = {beat_in.rad[RAD_W-3:0], 2'b00};
      beat_in_n.root  = {beat_in.root[ROOT_W-2:0], fits};
      beat_in_n.part  = fits ? PART_W'(pending - trial) : PART_W'(pending);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= beat_in_n;
      end
   end

   always_comb begin
      beat_out       = data_ff;
      beat_out.valid = valid_ff;
   end

endmodule

`default_nettype wire

>>> src/smallest_three_quaternion_decode.sv
// ----------------------------------------------------------------------------
// smallest_three_quaternion_decode: 48-bit smallest-three rotation decoder
// Each req beat carries one packed rotation; each rsp beat carries the four
// quaternion components in signed Q2.14.
// Input beat (req_tdata[47:0]): codes at bits 44:30, 29:15, 14:0, index of
// the dropped component at 46:45, bit 47 unused.
// Output beat (rsp_tdata): x in 15:0, y in 31:16, z in 47:32, w in 63:48.
// The path from req accept to rsp_tvalid runs through three dequantizer
// stages, one sum-of-squares stage, 31 square-root cells (one root bit per
// cell) and the output register. One beat enters per cycle while the
// output moves; the root cells set the depth.
// Reset clears every valid flag in the pipe, rsp_tvalid included; no
// result survives reset.
// While rsp_tvalid is high and rsp_tready low, the whole pipe holds and
// req_tready drops; otherwise a new beat is taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smallest_three_quaternion_decode
   import sqt3_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,   // packed_rotation[47:0]
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [RSP_DATA_W-1:0]   rsp_tdata    // quat_x, quat_y, quat_z, quat_w
);

   logic                     enable;
   logic [FRONT_STAGES-1:0]  valid_ff;
   drop_type                 drop_ff [FRONT_STAGES];
   logic [SQ_W-1:0]          square_a, square_b, square_c;
   logic signed [Q14_W-1:0]  value_a, value_b, value_c;
   logic [SUM_W-1:0]         sum_sq;
   cell_beat_type            head_in, head_ff;
   cell_beat_type            link [NUM_CELLS+1];
   cell_beat_type            tail;
   logic [ROOT_W-1:0]        rebuilt_sum;
   logic signed [Q14_W-1:0]  rebuilt;
   logic signed [Q14_W-1:0]  quat_x, quat_y, quat_z, quat_w;
   logic                     rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]    rsp_tdata_ff, rsp_tdata_in;

   // hold the whole pipe while a finished beat waits
   assign enable     = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = enable;

   sqt3_comp u_comp_a (
      .clock  (clock),
      .enable (enable),
      .code   (req_tdata[44:30]),
      .square (square_a),
      .value  (value_a)
   );

   sqt3_comp u_comp_b (
      .clock  (clock),
      .enable (enable),
      .code   (req_tdata[29:15]),
      .square (square_b),
      .value  (value_b)
   );

   sqt3_comp u_comp_c (
      .clock  (clock),
      .enable (enable),
      .code   (req_tdata[14:0]),
      .square (square_c),
      .value  (value_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[FRONT_STAGES-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         drop_ff[0] <= drop_type'(req_tdata[46:45]);
         for (int i = 1; i < FRONT_STAGES; i++) begin
            drop_ff[i] <= drop_ff[i-1];
         end
      end
   end

   // remainder 1 - sum of squares, clamped at zero
   assign sum_sq = SUM_W'(square_a) + SUM_W'(square_b) + SUM_W'(square_c);

   always_comb begin
      head_in             = '0;
      head_in.valid       = valid_ff[FRONT_STAGES-1];
      head_in.side.drop   = drop_ff[FRONT_STAGES-1];
      head_in.side.comp_a = value_a;
      head_in.side.comp_b = value_b;
      head_in.side.comp_c = value_c;
      head_in.rad         = (sum_sq >= ONE_Q60) ? '0 : RAD_W'(ONE_Q60 - sum_sq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (enable) begin
         head_ff <= head_in;
      end
   end

   assign link[0] = head_ff;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      sqt3_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .beat_in  (link[g]),
         .beat_out (link[g+1])
      );
   end

   assign tail        = link[NUM_CELLS];
   assign rebuilt_sum = tail.root + HALF_ROOT;
   assign rebuilt     = $signed(Q14_W'(rebuilt_sum[ROOT_W-1:16]));

   always_comb begin
      quat_x = tail.side.comp_a;
      quat_y = tail.side.comp_b;
      quat_z = tail.side.comp_c;
      quat_w = rebuilt;
      unique case (tail.side.drop)
         DROP_X: begin
            quat_x = rebuilt;
            quat_y = tail.side.comp_a;
            quat_z = tail.side.comp_b;
            quat_w = tail.side.comp_c;
         end
         DROP_Y: begin
            quat_y = rebuilt;
            quat_z = tail.side.comp_b;
            quat_w = tail.side.comp_c;
         end
         DROP_Z: begin
            quat_z = rebuilt;
            quat_w = tail.side.comp_c;
         end
         DROP_W: begin
            quat_w = rebuilt;
         end
         default: begin
            quat_w = rebuilt;
         end
      endcase
   end

   assign rsp_tdata_in = {quat_w, quat_z, quat_y, quat_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (enable) begin
         rsp_tvalid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && tail.valid) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // remainder of the root never exceeds twice the root
   assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> (34'(tail.part) <= 34'({tail.root, 1'b0})))
      else $error("root remainder out of range at chain end");

   // every component stays within the decodable range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[15:0])  <= 16384 && $signed(rsp_tdata[15:0])  >= -11585 &&
          $signed(rsp_tdata[31:16]) <= 16384 && $signed(rsp_tdata[31:16]) >= -11585 &&
          $signed(rsp_tdata[47:32]) <= 16384 && $signed(rsp_tdata[47:32]) >= -11585 &&
          $signed(rsp_tdata[63:48]) <= 16384 && $signed(rsp_tdata[63:48]) >= -11585))
      else $error("quaternion component out of range");

   // a new result only comes from a valid beat leaving the chain
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(tail.valid))
      else $error("result raised without a beat from the root chain");

endmodule

`default_nettype wire
